@@ rtl/core/stfg_pkg.sv @@
`default_nettype none

package stfg_pkg;

	localparam int SINE_TABLE_DEPTH_DEF = 1024;
	localparam int PCM_RATE_DEF         = 44100;

	localparam int FREQ_W = 15;
	localparam int LEN_W  = 24;
	localparam int FADE_W = 23;
	localparam int GAIN_W = 16;
	localparam int PCM_W  = 16;
	localparam int MAG_W  = 15;
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	localparam logic [FREQ_W-1:0] FREQ_RST = FREQ_W'(800);
	localparam logic [LEN_W-1:0]  LEN_RST  = LEN_W'(4410);
	localparam logic [FADE_W-1:0] FADE_RST = FADE_W'(441);
	localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(9830);

	localparam logic [PCM_W-1:0] PCM_MAX = PCM_W'(32767);

	typedef logic [1:0] reg_idx_t;

	localparam reg_idx_t REG_FREQ = 2'd0;
	localparam reg_idx_t REG_LEN  = 2'd1;
	localparam reg_idx_t REG_FADE = 2'd2;
	localparam reg_idx_t REG_GAIN = 2'd3;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	function automatic logic [MAG_W-1:0] q30_sine(input logic [63:0] x);
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic [63:0]        scaled;
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd210;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd272;
		sum  = sum + $signed(term);
		if (sum < 0) begin
			sum = 0;
		end
		scaled = (($unsigned(sum) * 64'd32767) + (64'd1 << 29)) >> 30;
		return scaled[MAG_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/stfg_div.sv @@
`default_nettype none

module stfg_div
	import stfg_pkg::*;
#(
	parameter int DW = 16,
	parameter int QW = 12
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW+QW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               busy,
	output logic [QW-1:0]      quo
);

	localparam int CW = $clog2(QW + 1);

	logic [DW-1:0] rem_q;
	logic [QW-1:0] lo_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;

	logic [DW:0] trial;
	logic [DW:0] diff;
	logic        fits;

	assign trial = {rem_q, lo_q[QW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[DW+QW-1:QW];
			lo_q  <= num[QW-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			lo_q  <= {lo_q[QW-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = lo_q;

endmodule

`default_nettype wire

@@ rtl/core/stfg_mul.sv @@
`default_nettype none

module stfg_mul
	import stfg_pkg::*;
#(
	parameter int AW = 40,
	parameter int BW = 24
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [AW-1:0] a,
	input  wire logic [BW-1:0] b,
	output logic               busy,
	output logic [AW+BW-1:0]   prod
);

	localparam int CW = $clog2(BW + 1);

	logic [AW-1:0]    a_q;
	logic [AW+BW-1:0] prod_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [AW:0]      upper;

	assign upper = {1'b0, prod_q[AW+BW-1:BW]} + (prod_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(BW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			prod_q <= {{AW{1'b0}}, b};
		end else if (busy_q) begin
			prod_q <= {upper, prod_q[BW-1:1]};
		end
	end

	assign busy = busy_q;
	assign prod = prod_q;

endmodule

`default_nettype wire

@@ rtl/core/stfg_rom.sv @@
`default_nettype none

module stfg_rom
	import stfg_pkg::*;
#(
	parameter int DEPTH = SINE_TABLE_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [$clog2(DEPTH+1)-1:0]   addr,
	output logic      [MAG_W-1:0]             data
);

	logic [MAG_W-1:0] tab_w [0:DEPTH];
	logic [MAG_W-1:0] data_q;

	for (genvar k = 0; k <= DEPTH; k++) begin : g_tab
		localparam logic [63:0] ARG = (HALF_PI_Q30 * 64'(k)) / 64'(DEPTH);
		assign tab_w[k] = q30_sine(ARG);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= tab_w[addr];
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

@@ rtl/core/sine_tone_with_fade_generator_top.sv @@
// channel  | handshake          | payload
// req      | req_valid/req_ready | restart
// smp      | smp_valid/smp_ready | pcm_sample, tone_end
// cfg      | psel/penable/pready | paddr, pwrite, pwdata, prdata
//
// Each item takes two 24-step passes of the shared bit-serial multiplier and
// a 16-step serial divide for the envelope. A zero tone length goes straight
// to the output state with a zero sample. Reset restores the register defaults
// and clears the sample index and phase. A stalled result sits in the output
// register; the next item is taken and held back only at its final load.
`default_nettype none

module sine_tone_with_fade_generator_top
	import stfg_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
	parameter int PCM_RATE         = PCM_RATE_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire logic              restart,
	output logic                   smp_valid,
	input  wire logic              smp_ready,
	output logic signed [PCM_W-1:0] pcm_sample,
	output logic                   tone_end,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	localparam int PH_W    = $clog2(PCM_RATE + 1);
	localparam int P_W     = $clog2(4 * SINE_TABLE_DEPTH);
	localparam int ADDR_W  = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int ACC_W   = ((PH_W > FREQ_W) ? PH_W : FREQ_W) + 1;
	localparam int MUL_A_W = GAIN_W + LEN_W;
	localparam int MUL_B_W = LEN_W;
	localparam int Y_W     = FADE_W + PCM_W;

	localparam logic [PH_W-1:0]     SR_PH    = PH_W'(PCM_RATE);
	localparam logic [ACC_W-1:0]    SR_ACC   = ACC_W'(PCM_RATE);
	localparam logic [PH_W+P_W-1:0] PT_SCALE = (PH_W+P_W)'(4 * SINE_TABLE_DEPTH);
	localparam logic [P_W-1:0]      QD1      = P_W'(SINE_TABLE_DEPTH);
	localparam logic [P_W-1:0]      QD2      = P_W'(2 * SINE_TABLE_DEPTH);
	localparam logic [P_W-1:0]      QD3      = P_W'(3 * SINE_TABLE_DEPTH);
	localparam logic [ADDR_W-1:0]   TOP_ADDR = ADDR_W'(SINE_TABLE_DEPTH);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ENV  = 3'd1;
	localparam logic [2:0] ST_WAIT = 3'd2;
	localparam logic [2:0] ST_ROM  = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0]        state_q;
	logic [FREQ_W-1:0] freq_q;
	logic [LEN_W-1:0]  len_q;
	logic [FADE_W-1:0] fade_q;
	logic [GAIN_W-1:0] gain_q;
	logic [LEN_W-1:0]  idx_q;
	logic [PH_W-1:0]   phase_q;
	logic [ACC_W-1:0]  acc_q;
	logic              last_q;
	logic              neg_q;
	logic [FADE_W-1:0] den_q;
	logic [MUL_A_W-1:0] gn_q;
	logic [PCM_W-1:0]  res_q;
	logic              smp_valid_q;
	logic [PCM_W-1:0]  pcm_q;
	logic              end_q;

	reg_idx_t wr_idx;
	logic     wr_en;

	logic [LEN_W-1:0]  len_m1;
	logic [LEN_W-1:0]  tail;
	logic [LEN_W:0]    ramp_sum;
	logic              in_ramp;
	logic              out_ramp;
	logic [LEN_W-1:0]  env_num;
	logic [FADE_W-1:0] env_den;
	logic              acc_done;

	logic [P_W-1:0]    pt;
	logic [1:0]        quad;
	logic [P_W-1:0]    off;
	logic [ADDR_W-1:0] rom_addr;
	logic              rom_en;
	logic [MAG_W-1:0]  rom_data;

	logic                 mul_start;
	logic [MUL_A_W-1:0]   mul_a;
	logic [MUL_B_W-1:0]   mul_b;
	logic                 mul_busy;
	logic [MUL_A_W+MUL_B_W-1:0] mul_prod;

	logic               ph_start;
	logic               ph_busy;
	logic [P_W-1:0]     ph_quo;
	logic               env_start;
	logic               env_busy;
	logic [PCM_W-1:0]   env_quo;
	logic [PCM_W-1:0]   mag_res;
	logic               wait_done;
	logic               out_load;

	// configuration registers
	assign wr_idx = paddr[3:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= FREQ_RST;
			len_q  <= LEN_RST;
			fade_q <= FADE_RST;
			gain_q <= GAIN_RST;
		end else if (wr_en) begin
			unique case (wr_idx)
				REG_FREQ: freq_q <= pwdata[FREQ_W-1:0];
				REG_LEN:  len_q  <= pwdata[LEN_W-1:0];
				REG_FADE: fade_q <= pwdata[FADE_W-1:0];
				REG_GAIN: gain_q <= pwdata[GAIN_W-1:0];
				default:  freq_q <= freq_q;
			endcase
		end
	end

	always_comb begin
		unique case (wr_idx)
			REG_FREQ: prdata = APB_DW'(freq_q);
			REG_LEN:  prdata = APB_DW'(len_q);
			REG_FADE: prdata = APB_DW'(fade_q);
			REG_GAIN: prdata = APB_DW'(gain_q);
			default:  prdata = '0;
		endcase
	end

	// envelope fraction
	assign len_m1   = len_q - 1'b1;
	assign tail     = len_m1 - idx_q;
	assign ramp_sum = (LEN_W+1)'(idx_q) + (LEN_W+1)'(fade_q);
	assign in_ramp  = idx_q < LEN_W'(fade_q);
	assign out_ramp = ramp_sum >= (LEN_W+1)'(len_q);

	always_comb begin
		env_num = LEN_W'(1);
		env_den = FADE_W'(1);
		if (fade_q != '0) begin
			if (in_ramp) begin
				env_num = idx_q;
				env_den = fade_q;
			end else if (out_ramp) begin
				env_num = tail;
				env_den = fade_q;
			end
		end
	end

	// quadrant fold
	assign pt = ph_quo;

	always_comb begin
		if (pt >= QD3) begin
			quad = 2'd3;
			off  = pt - QD3;
		end else if (pt >= QD2) begin
			quad = 2'd2;
			off  = pt - QD2;
		end else if (pt >= QD1) begin
			quad = 2'd1;
			off  = pt - QD1;
		end else begin
			quad = 2'd0;
			off  = pt;
		end
	end

	assign rom_addr  = quad[0] ? (TOP_ADDR - ADDR_W'(off)) : ADDR_W'(off);
	assign acc_done  = acc_q < SR_ACC;
	assign wait_done = !ph_busy && !mul_busy && acc_done;
	assign rom_en    = (state_q == ST_WAIT) && wait_done;

	assign mul_start = (state_q == ST_ENV) || (state_q == ST_ROM);
	assign mul_a     = (state_q == ST_ROM) ? gn_q : MUL_A_W'(gain_q);
	assign mul_b     = (state_q == ST_ROM) ? MUL_B_W'(rom_data) : env_num;
	assign ph_start  = (state_q == ST_ENV);
	assign env_start = (state_q == ST_MUL) && !mul_busy;

	assign mag_res  = env_quo[PCM_W-1] ? PCM_MAX : env_quo;
	assign out_load = (state_q == ST_OUT) && (!smp_valid_q || smp_ready);

	stfg_div #(
		.DW (PH_W),
		.QW (P_W)
	) u_div_ph (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ph_start),
		.num    ((PH_W+P_W)'(phase_q) * PT_SCALE),
		.den    (SR_PH),
		.busy   (ph_busy),
		.quo    (ph_quo)
	);

	stfg_mul #(
		.AW (MUL_A_W),
		.BW (MUL_B_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.prod   (mul_prod)
	);

	stfg_rom #(
		.DEPTH (SINE_TABLE_DEPTH)
	) u_rom (
		.clk  (clk),
		.en   (rom_en),
		.addr (rom_addr),
		.data (rom_data)
	);

	stfg_div #(
		.DW (FADE_W),
		.QW (PCM_W)
	) u_div_env (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (env_start),
		.num    (mul_prod[15 +: Y_W]),
		.den    (den_q),
		.busy   (env_busy),
		.quo    (env_quo)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			phase_q <= '0;
			acc_q   <= '0;
		end else begin
			if (state_q == ST_ENV) begin
				acc_q <= ACC_W'(phase_q) + ACC_W'(freq_q);
			end else if (!acc_done) begin
				acc_q <= acc_q - SR_ACC;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						if (restart || (len_q == '0) || (idx_q >= len_q)) begin
							idx_q   <= '0;
							phase_q <= '0;
						end
						state_q <= (len_q == '0) ? ST_OUT : ST_ENV;
					end
				end
				ST_ENV: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (wait_done) begin
						idx_q   <= last_q ? '0 : idx_q + 1'b1;
						phase_q <= last_q ? '0 : PH_W'(acc_q);
						state_q <= ST_ROM;
					end
				end
				ST_ROM: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (!mul_busy) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!env_busy) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && req_valid && (len_q == '0)) begin
			res_q  <= '0;
			last_q <= 1'b1;
		end
		if (state_q == ST_ENV) begin
			last_q <= idx_q == len_m1;
			den_q  <= env_den;
		end
		if (rom_en) begin
			neg_q <= quad[1];
			gn_q  <= mul_prod[MUL_A_W-1:0];
		end
		if ((state_q == ST_DIV) && !env_busy) begin
			res_q <= neg_q ? (PCM_W'(0) - mag_res) : mag_res;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_valid_q <= 1'b0;
		end else if (out_load) begin
			smp_valid_q <= 1'b1;
		end else if (smp_ready) begin
			smp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pcm_q <= res_q;
			end_q <= last_q;
		end
	end

	assign req_ready  = (state_q == ST_IDLE);
	assign smp_valid  = smp_valid_q;
	assign pcm_sample = $signed(pcm_q);
	assign tone_end   = end_q;

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q < SR_PH)
		else $error("phase out of range");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT) |-> (idx_q < len_q))
		else $error("sample index not below tone length during a sample");

	a_rom_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rom_en |-> (rom_addr <= TOP_ADDR))
		else $error("sine table address beyond quarter wave");

	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid_q |-> (pcm_q != {1'b1, {(PCM_W-1){1'b0}}}))
		else $error("sample escaped saturation");

	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(smp_valid_q) |-> ($past(state_q) == ST_OUT))
		else $error("result item raised outside the output state");

endmodule

`default_nettype wire
